>>> hw/rtl/swtm_pkg.sv
// Shared types, codes and constants of the software timer multiplexer.
`default_nettype none

package swtm_pkg;

  localparam int SlotCountDef    = 16;
  localparam int CompareLimitDef = 65535;
  localparam int MaxFired        = 16;
  localparam int FireCntW        = 5;
  localparam int RemW            = 26;
  localparam int PeriodW         = 24;
  localparam int IdentW          = 16;
  localparam int ElapsedW        = 17;
  localparam int CounterW        = 16;

  localparam logic [1:0] ActTick  = 2'd0;
  localparam logic [1:0] ActStart = 2'd1;
  localparam logic [1:0] ActStop  = 2'd2;

  localparam logic [1:0] KindFired   = 2'd0;
  localparam logic [1:0] KindSummary = 2'd1;
  localparam logic [1:0] KindAck     = 2'd2;

  typedef struct packed {
    logic [1:0]          action;
    logic [3:0]          slot;
    logic [IdentW-1:0]   timer_ident;
    logic [PeriodW-1:0]  period;
    logic                repeat_req;
    logic [ElapsedW-1:0] elapsed;
    logic [CounterW-1:0] counter_now;
  } item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [IdentW-1:0]   fired_ident;
    logic [CounterW-1:0] next_compare;
    logic                running;
    logic [31:0]         tick_total;
    logic [CounterW-1:0] jitter_peak;
    logic [CounterW-1:0] jitter_peak_ever;
    logic [31:0]         jitter_sum;
    logic                last;
  } result_t;

  // One row of the timer table.
  typedef struct packed {
    logic signed [RemW-1:0] rem;
    logic [PeriodW-1:0]     period;
    logic                   reload;
    logic [IdentW-1:0]      ident;
  } slot_entry_t;

  // What the slot unit hands back to the sequencer for one visited slot.
  typedef struct packed {
    logic signed [RemW-1:0] rem;
    logic                   fired;
    logic                   live;
    logic signed [RemW-1:0] least;
    logic                   have;
  } slot_upd_t;

endpackage

`default_nettype wire

>>> hw/rtl/software_timer_multiplexer_top.sv
// Start and stop are acknowledged by one result beat in the cycle after acceptance; busy stays low.
// A tick keeps busy high through the slot walk and the summary state; no new item is taken while busy is high.
// The tick walks the slots one per cycle through the single table read port and the slot unit;
// fired beats follow in slot order and the summary beat comes last, registered from the summary state.
// Results cannot be stalled. Reset clears every live bit, the statistics and the running flag.
`default_nettype none

module software_timer_multiplexer_top #(
  parameter int SLOT_COUNT    = swtm_pkg::SlotCountDef,
  parameter int COMPARE_LIMIT = swtm_pkg::CompareLimitDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire swtm_pkg::item_t item_i,
  output logic                 result_valid_o,
  output swtm_pkg::result_t    result_o
);

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RemW = swtm_pkg::RemW;
  localparam int CntW = swtm_pkg::CounterW;

  typedef enum logic [1:0] {StIdle, StRun, StSum} state_e;

  state_e                           state_q, state_d;
  logic [IdxW-1:0]                  idx_q, idx_d;
  logic [SLOT_COUNT-1:0]            live_q, live_d;
  logic [SLOT_COUNT-1:0]            live_after_stop;
  logic [swtm_pkg::FireCntW-1:0]    fire_cnt_q, fire_cnt_d;
  logic signed [RemW-1:0]           least_q, least_d;
  logic                             have_q, have_d;
  logic [swtm_pkg::ElapsedW-1:0]    elapsed_q, elapsed_d;
  logic [CntW-1:0]                  cnow_q, cnow_d;
  logic [31:0]                      tick_q, tick_d;
  logic [31:0]                      jsum_q, jsum_d;
  logic [CntW-1:0]                  jhigh_q, jhigh_d;
  logic [CntW-1:0]                  jever_q, jever_d;
  logic                             running_q, running_d;
  logic                             res_valid_q, res_valid_d;
  swtm_pkg::result_t                res_q, res_d;

  logic                             accept;
  logic                             slot_ok;
  logic [IdxW-1:0]                  slot_idx;
  logic                             last_idx;
  logic                             tbl_we;
  logic [IdxW-1:0]                  tbl_waddr;
  logic [IdxW-1:0]                  tbl_raddr;
  swtm_pkg::slot_entry_t            tbl_wdata;
  swtm_pkg::slot_entry_t            tbl_rdata;
  swtm_pkg::slot_upd_t              upd;
  logic signed [RemW:0]             compare_sum;
  logic [CntW-1:0]                  next_cmp;

  swtm_table #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  swtm_slot_unit u_slot_unit (
    .entry_i  (tbl_rdata),
    .live_i   (live_q[idx_q]),
    .elapsed_i(elapsed_q),
    .least_i  (least_q),
    .have_i   (have_q),
    .upd_o    (upd)
  );

  assign accept   = start && (state_q == StIdle);
  assign slot_ok  = (int'(item_i.slot) < SLOT_COUNT);
  assign slot_idx = IdxW'(item_i.slot);
  assign last_idx = (idx_q == IdxW'(SLOT_COUNT - 1));

  always_comb begin
    live_after_stop = live_q;
    if (slot_ok) begin
      live_after_stop[slot_idx] = 1'b0;
    end
  end

  // Next compare value: least remaining time plus the sampled counter, clamped.
  always_comb begin
    compare_sum = $signed({least_q[RemW-1], least_q})
                + $signed({{(RemW + 1 - CntW){1'b0}}, cnow_q});
    if (!have_q || (compare_sum < $signed({(RemW + 1){1'b0}}))) begin
      next_cmp = '0;
    end else if (compare_sum > $signed((RemW + 1)'(COMPARE_LIMIT))) begin
      next_cmp = CntW'(COMPARE_LIMIT);
    end else begin
      next_cmp = compare_sum[CntW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    live_d      = live_q;
    fire_cnt_d  = fire_cnt_q;
    least_d     = least_q;
    have_d      = have_q;
    elapsed_d   = elapsed_q;
    cnow_d      = cnow_q;
    tick_d      = tick_q;
    jsum_d      = jsum_q;
    jhigh_d     = jhigh_q;
    jever_d     = jever_q;
    running_d   = running_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    tbl_we      = 1'b0;
    tbl_waddr   = idx_q;
    tbl_wdata   = tbl_rdata;
    tbl_raddr   = '0;

    res_d.tick_total       = tick_q;
    res_d.jitter_peak      = jhigh_q;
    res_d.jitter_peak_ever = jever_q;
    res_d.jitter_sum       = jsum_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (item_i.action) inside
            swtm_pkg::ActTick: begin
              tick_d     = tick_q + 32'd1;
              jsum_d     = jsum_q + 32'(item_i.counter_now);
              jhigh_d    = (item_i.counter_now > jhigh_q) ? item_i.counter_now : jhigh_q;
              jever_d    = (item_i.counter_now > jever_q) ? item_i.counter_now : jever_q;
              elapsed_d  = item_i.elapsed;
              cnow_d     = item_i.counter_now;
              idx_d      = '0;
              fire_cnt_d = '0;
              least_d    = '0;
              have_d     = 1'b0;
              state_d    = StRun;
            end
            swtm_pkg::ActStart, swtm_pkg::ActStop: begin
              if (slot_ok) begin
                if (item_i.action == swtm_pkg::ActStart) begin
                  tbl_we           = 1'b1;
                  tbl_waddr        = slot_idx;
                  tbl_wdata.rem    = RemW'(item_i.period);
                  tbl_wdata.period = item_i.period;
                  tbl_wdata.reload = item_i.repeat_req;
                  tbl_wdata.ident  = item_i.timer_ident;
                  live_d[slot_idx] = 1'b1;
                  running_d        = 1'b1;
                end else begin
                  // A stopped slot's row is left as is: its live bit guards every read.
                  live_d    = live_after_stop;
                  running_d = |live_after_stop;
                end
              end
              res_valid_d        = 1'b1;
              res_d.kind         = swtm_pkg::KindAck;
              res_d.fired_ident  = '0;
              res_d.next_compare = '0;
              res_d.running      = running_d;
              res_d.last         = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      StRun: begin
        if (live_q[idx_q]) begin
          tbl_we        = 1'b1;
          tbl_wdata.rem = upd.rem;
          live_d[idx_q] = upd.live;
          least_d       = upd.least;
          have_d        = upd.have;
          if (upd.fired && (fire_cnt_q < swtm_pkg::FireCntW'(swtm_pkg::MaxFired))) begin
            fire_cnt_d         = fire_cnt_q + swtm_pkg::FireCntW'(1);
            res_valid_d        = 1'b1;
            res_d.kind         = swtm_pkg::KindFired;
            res_d.fired_ident  = tbl_rdata.ident;
            res_d.next_compare = '0;
            res_d.running      = 1'b0;
            res_d.last         = 1'b0;
          end
        end
        // Fetch the next row while this one is written back.
        if (last_idx) begin
          state_d = StSum;
        end else begin
          idx_d     = idx_q + IdxW'(1);
          tbl_raddr = idx_q + IdxW'(1);
        end
      end
      StSum: begin
        running_d          = have_q;
        res_valid_d        = 1'b1;
        res_d.kind         = swtm_pkg::KindSummary;
        res_d.fired_ident  = '0;
        res_d.next_compare = next_cmp;
        res_d.running      = have_q;
        res_d.last         = 1'b1;
        state_d            = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      live_q      <= '0;
      fire_cnt_q  <= '0;
      have_q      <= 1'b0;
      tick_q      <= '0;
      jsum_q      <= '0;
      jhigh_q     <= '0;
      jever_q     <= '0;
      running_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      live_q      <= live_d;
      fire_cnt_q  <= fire_cnt_d;
      have_q      <= have_d;
      tick_q      <= tick_d;
      jsum_q      <= jsum_d;
      jhigh_q     <= jhigh_d;
      jever_q     <= jever_d;
      running_q   <= running_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    least_q   <= least_d;
    elapsed_q <= elapsed_d;
    cnow_q    <= cnow_d;
    res_q     <= res_d;
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // A fired beat always comes while the tick is still being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.kind == swtm_pkg::KindFired)) |-> (busy && !result_o.last))
    else $error("fired beat outside a tick pass");

  // Acknowledges never overlap a tick pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.kind == swtm_pkg::KindAck)) |-> !busy)
    else $error("acknowledge beat during a tick pass");

  // A summary with nothing live never requests a compare value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.kind == swtm_pkg::KindSummary) && !result_o.running)
      |-> (result_o.next_compare == '0))
    else $error("compare value given with no live timer");

  // An accepted tick starts the slot walk at the first slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.action == swtm_pkg::ActTick)) |=> (busy && (idx_q == '0)))
    else $error("tick did not start the slot walk");

  // The summary beat comes in the cycle after the summary state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSum) |=> (result_valid_o && (result_o.kind == swtm_pkg::KindSummary)))
    else $error("summary beat missing after the slot walk");

endmodule

`default_nettype wire

>>> hw/rtl/swtm_table.sv
// Timer table memory: one write port, one registered read port.
`default_nettype none

module swtm_table #(
  parameter int SLOT_COUNT = swtm_pkg::SlotCountDef,
  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [IdxW-1:0]       waddr_i,
  input  wire swtm_pkg::slot_entry_t wdata_i,
  input  wire logic [IdxW-1:0]       raddr_i,
  output swtm_pkg::slot_entry_t      rdata_o
);

  swtm_pkg::slot_entry_t mem_q [SLOT_COUNT];
  swtm_pkg::slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/swtm_slot_unit.sv
// Shared slot unit: subtract elapsed ticks, detect expiry, reload and track the minimum.
`default_nettype none

module swtm_slot_unit (
  input  wire swtm_pkg::slot_entry_t                  entry_i,
  input  wire logic                                   live_i,
  input  wire logic [swtm_pkg::ElapsedW-1:0]          elapsed_i,
  input  wire logic signed [swtm_pkg::RemW-1:0]       least_i,
  input  wire logic                                   have_i,
  output swtm_pkg::slot_upd_t                         upd_o
);

  localparam int RemW = swtm_pkg::RemW;

  logic signed [RemW:0]   diff;
  logic signed [RemW-1:0] rem_sat;
  logic signed [RemW:0]   reloaded;
  logic                   expired;
  logic signed [RemW-1:0] rem_new;
  logic                   live_new;

  always_comb begin
    diff = $signed({entry_i.rem[RemW-1], entry_i.rem})
         - $signed({{(RemW + 1 - swtm_pkg::ElapsedW){1'b0}}, elapsed_i});
    // Saturate at the most negative value that 26 signed bits hold.
    if (diff < $signed({2'b11, {(RemW - 1){1'b0}}})) begin
      rem_sat = {1'b1, {(RemW - 1){1'b0}}};
    end else begin
      rem_sat = diff[RemW-1:0];
    end
    expired  = (rem_sat <= $signed({RemW{1'b0}}));
    reloaded = $signed({rem_sat[RemW-1], rem_sat})
             + $signed({{(RemW + 1 - swtm_pkg::PeriodW){1'b0}}, entry_i.period});
    rem_new  = rem_sat;
    live_new = live_i;
    if (expired) begin
      if (entry_i.reload) begin
        rem_new = reloaded[RemW-1:0];
      end else begin
        rem_new  = '0;
        live_new = 1'b0;
      end
    end

    upd_o.rem   = rem_new;
    upd_o.fired = live_i && expired;
    upd_o.live  = live_new;
    upd_o.least = least_i;
    upd_o.have  = have_i;
    if (live_new && (!have_i || (rem_new < least_i))) begin
      upd_o.least = rem_new;
      upd_o.have  = 1'b1;
    end
  end

endmodule

`default_nettype wire
